[rtl/core/can_frame_to_ascii_line_top_macros.svh]
// Assertion macros shared by the frame-to-text modules.
`ifndef CAN_FRAME_TO_ASCII_LINE_TOP_MACROS_SVH
`define CAN_FRAME_TO_ASCII_LINE_TOP_MACROS_SVH

// Checked only while out of reset.
`define CFAL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define CFAL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/core/cfal_pkg.sv]
`default_nettype none

package cfal_pkg;

  localparam int LINE_LEN   = 27;
  localparam int COUNT_W    = 5;
  localparam int ID_W       = 29;
  localparam int LEN_W      = 4;
  localparam int BYTE_W     = 8;
  localparam int DATA_BYTES = 8;
  localparam int ID_LANES   = 4;
  localparam int S_TDATA_W  = 104;
  localparam int S_TUSER_W  = 2;

  localparam logic [LEN_W-1:0]   MAX_LEN  = 4'd8;
  localparam logic [COUNT_W-1:0] STD_BASE = 5'd6;
  localparam logic [COUNT_W-1:0] EXT_BASE = 5'd11;

  typedef logic [BYTE_W-1:0] char_t;
  // Index 0 is the low nibble, index 1 the high nibble.
  typedef char_t [1:0] hex_pair_t;

  localparam char_t CHAR_CR   = 8'h0D;
  localparam char_t CHAR_ZERO = 8'h30;
  localparam char_t CHAR_A    = 8'h41;
  localparam char_t CHAR_STD_DATA = 8'h74;  // t
  localparam char_t CHAR_EXT_DATA = 8'h54;  // T
  localparam char_t CHAR_STD_RTR  = 8'h72;  // r
  localparam char_t CHAR_EXT_RTR  = 8'h52;  // R

  typedef struct packed {
    char_t [LINE_LEN-1:0] chars;
    logic [COUNT_W-1:0]   count;
  } line_t;

  function automatic char_t hex_char(input logic [3:0] nib);
    char_t c;
    if (nib < 4'd10) begin
      c = CHAR_ZERO + {4'b0000, nib};
    end else begin
      c = CHAR_A + {4'b0000, nib} - 8'd10;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/core/cfal_hex_lane.sv]
`default_nettype none

module cfal_hex_lane (
  input  wire logic [7:0]         value_i,
  output cfal_pkg::hex_pair_t     chars_o
);
  import cfal_pkg::*;

  assign chars_o[0] = hex_char(value_i[3:0]);
  assign chars_o[1] = hex_char(value_i[7:4]);

endmodule

`default_nettype wire

[rtl/core/cfal_line_merge.sv]
`default_nettype none
`include "can_frame_to_ascii_line_top_macros.svh"

module cfal_line_merge (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_valid_i,
  output logic                        s_ready_o,
  input  wire logic                   ext_i,
  input  wire logic                   rtr_i,
  input  wire logic [3:0]             len_i,
  input  wire cfal_pkg::hex_pair_t    id_chars_i [cfal_pkg::ID_LANES],
  input  wire cfal_pkg::hex_pair_t    len_chars_i,
  input  wire cfal_pkg::hex_pair_t    data_chars_i [cfal_pkg::DATA_BYTES],
  output logic                        line_valid_o,
  input  wire logic                   line_ready_i,
  output cfal_pkg::line_t             line_o
);
  import cfal_pkg::*;

  line_t line_d;
  line_t pend_q;
  logic  pend_valid_q;
  logic  s_hs;
  logic  len_ok;
  logic  pend_stall;
  char_t last_char;

  always_comb begin
    line_d.count = (ext_i ? EXT_BASE : STD_BASE)
                   + (rtr_i ? '0 : COUNT_W'({len_i, 1'b0}));
    for (int p = 0; p < LINE_LEN; p++) begin
      line_d.chars[p] = CHAR_CR;
    end
    if (ext_i) begin
      line_d.chars[0] = rtr_i ? CHAR_EXT_RTR : CHAR_EXT_DATA;
      for (int j = 0; j < 2 * ID_LANES; j++) begin
        line_d.chars[1 + j] = id_chars_i[(7 - j) >> 1][(7 - j) & 1];
      end
      line_d.chars[9] = len_chars_i[0];
      for (int k = 0; k < DATA_BYTES; k++) begin
        line_d.chars[10 + 2 * k] = data_chars_i[k][1];
        line_d.chars[11 + 2 * k] = data_chars_i[k][0];
      end
    end else begin
      line_d.chars[0] = rtr_i ? CHAR_STD_RTR : CHAR_STD_DATA;
      for (int j = 0; j < 3; j++) begin
        line_d.chars[1 + j] = id_chars_i[(2 - j) >> 1][(2 - j) & 1];
      end
      line_d.chars[4] = len_chars_i[0];
      for (int k = 0; k < DATA_BYTES; k++) begin
        line_d.chars[5 + 2 * k] = data_chars_i[k][1];
        line_d.chars[6 + 2 * k] = data_chars_i[k][0];
      end
    end
    // The carriage return overrides whatever sits at the last position.
    for (int p = 0; p < LINE_LEN; p++) begin
      if (COUNT_W'(p) == line_d.count - 5'd1) begin
        line_d.chars[p] = CHAR_CR;
      end
    end
  end

  assign s_ready_o    = !pend_valid_q || line_ready_i;
  assign s_hs         = s_valid_i && s_ready_o;
  assign line_valid_o = pend_valid_q;
  assign line_o       = pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (s_hs) begin
      pend_valid_q <= 1'b1;
    end else if (line_ready_i) begin
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_hs) begin
      pend_q <= line_d;
    end
  end

  assign len_ok     = (pend_q.count >= STD_BASE) && (pend_q.count <= 5'd27);
  assign last_char  = pend_q.chars[pend_q.count - 5'd1];
  assign pend_stall = pend_valid_q && !line_ready_i;

  `CFAL_ASSERT(a_pend_after_accept, s_hs |=> pend_valid_q, "accepted frame not held")
  `CFAL_ASSERT(a_pend_len, pend_valid_q |-> len_ok, "bad line length")
  `CFAL_ASSERT(a_pend_cr, pend_valid_q |-> last_char == CHAR_CR, "line not ended by CR")
  `CFAL_ASSERT(a_pend_hold, pend_stall |=> pend_valid_q && $stable(pend_q), "pending line lost")

endmodule

`default_nettype wire

[rtl/core/cfal_line_ser.sv]
`default_nettype none
`include "can_frame_to_ascii_line_top_macros.svh"

module cfal_line_ser (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          line_valid_i,
  output logic               line_ready_o,
  input  wire cfal_pkg::line_t line_i,
  output logic               m_tvalid_o,
  input  wire logic          m_tready_i,
  output logic [7:0]         m_tdata_o,
  output logic               m_tlast_o
);
  import cfal_pkg::*;

  char_t [LINE_LEN-1:0] chars_q;
  logic [COUNT_W-1:0]   rem_q;
  logic                 busy;
  logic                 m_hs;
  logic                 load;

  assign busy         = rem_q != '0;
  assign m_tvalid_o   = busy;
  assign m_tdata_o    = chars_q[0];
  assign m_tlast_o    = rem_q == 5'd1;
  assign m_hs         = m_tvalid_o && m_tready_i;
  assign line_ready_o = !busy || (m_hs && m_tlast_o);
  assign load         = line_valid_i && line_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (load) begin
      rem_q <= line_i.count;
    end else if (m_hs) begin
      rem_q <= rem_q - 5'd1;
    end
  end

  // The line drains from the low end, one character per beat.
  always_ff @(posedge clk_i) begin
    if (load) begin
      chars_q <= line_i.chars;
    end else if (m_hs) begin
      chars_q <= {CHAR_CR, chars_q[LINE_LEN-1:1]};
    end
  end

  `CFAL_ASSERT_ALWAYS(a_last_is_cr, m_tlast_o |-> m_tdata_o == CHAR_CR, "last beat is not CR")
  `CFAL_ASSERT(a_load_count, load |=> rem_q == $past(line_i.count), "line length not loaded")
  `CFAL_ASSERT(a_mid_line, m_hs && !m_tlast_o |=> m_tvalid_o, "line cut short")

endmodule

`default_nettype wire

[rtl/core/can_frame_to_ascii_line_top.sv]
// Received CAN frame to ASCII text line (type letter, hex identifier,
// length digit, hex data bytes, carriage return).
// Input channel s_axis: one beat carries one frame. tuser holds the
// extended and remote flags, tdata the identifier, length code and the
// eight payload bytes.
// Output channel m_axis: one beat per ASCII character; tlast marks the
// closing carriage return. A line is 6 to 27 beats long.
// The frame is registered first in the merge register and then in the
// output shift register before its first character appears; the hex
// lanes and the merge logic are combinational. The output shift
// register sends one character per cycle while the receiver is ready.
// One further frame is held in the merge register while a line drains,
// so frames follow each other without a gap on the output.
// Reset empties both registers; nothing is sent until a new frame.
// When the receiver stalls, the current character holds, and input beats
// are refused once the merge register is full.
`default_nettype none

module can_frame_to_ascii_line_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // identifier[28:0], data_length[32:29], data_byte_0..7 from bit 33 up
  input  wire logic [cfal_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  // extended_id[0], remote_request[1]
  input  wire logic [cfal_pkg::S_TUSER_W-1:0]   s_axis_tuser_i,
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // text_byte[7:0]
  output logic [7:0]                            m_axis_tdata_o,
  output logic                                  m_axis_tlast_o
);
  import cfal_pkg::*;

  logic             ext;
  logic             rtr;
  logic [ID_W-1:0]  ident;
  logic [LEN_W-1:0] len_raw;
  logic [LEN_W-1:0] len_c;
  logic [31:0]      id_val;
  hex_pair_t        id_chars [ID_LANES];
  hex_pair_t        len_chars;
  hex_pair_t        data_chars [DATA_BYTES];
  logic             line_valid;
  logic             line_ready;
  line_t            line;

  assign ext     = s_axis_tuser_i[0];
  assign rtr     = s_axis_tuser_i[1];
  assign ident   = s_axis_tdata_i[ID_W-1:0];
  assign len_raw = s_axis_tdata_i[ID_W+LEN_W-1:ID_W];
  assign len_c   = (len_raw > MAX_LEN) ? MAX_LEN : len_raw;
  // Standard frames report only the low 11 identifier bits.
  assign id_val  = ext ? {3'b000, ident} : {21'd0, ident[10:0]};

  for (genvar g = 0; g < ID_LANES; g++) begin : g_id_lane
    cfal_hex_lane u_lane (
      .value_i (id_val[8*g +: 8]),
      .chars_o (id_chars[g])
    );
  end

  cfal_hex_lane u_len_lane (
    .value_i ({4'b0000, len_c}),
    .chars_o (len_chars)
  );

  for (genvar g = 0; g < DATA_BYTES; g++) begin : g_data_lane
    cfal_hex_lane u_lane (
      .value_i (s_axis_tdata_i[ID_W+LEN_W+BYTE_W*g +: BYTE_W]),
      .chars_o (data_chars[g])
    );
  end

  cfal_line_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid_i),
    .s_ready_o    (s_axis_tready_o),
    .ext_i        (ext),
    .rtr_i        (rtr),
    .len_i        (len_c),
    .id_chars_i   (id_chars),
    .len_chars_i  (len_chars),
    .data_chars_i (data_chars),
    .line_valid_o (line_valid),
    .line_ready_i (line_ready),
    .line_o       (line)
  );

  cfal_line_ser u_ser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .line_valid_i (line_valid),
    .line_ready_o (line_ready),
    .line_i       (line),
    .m_tvalid_o   (m_axis_tvalid_o),
    .m_tready_i   (m_axis_tready_i),
    .m_tdata_o    (m_axis_tdata_o),
    .m_tlast_o    (m_axis_tlast_o)
  );

endmodule

`default_nettype wire
